// File: design/pcrc_pkg.sv
// ----------------------------------------------------------------------------
// pcrc_pkg
// Shared types, constants and the CRC-32 long-division step for the payload
// word CRC checker.
// ----------------------------------------------------------------------------
package pcrc_pkg;

    localparam int WORD_W          = 32;
    localparam int ACC_W           = 48;
    localparam int STEPS           = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // 0x104C11DB7 shifted left 15, top bit at bit 47
    localparam logic [ACC_W-1:0] CRC_DIVISOR = {33'h1_04C1_1DB7, 15'd0};

    typedef enum logic [1:0] {
        POS_FIRST,
        POS_SECOND,
        POS_LATER
    } t_pos;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        t_pos              pos;
    } t_entry;

    // sixteen xor-shift steps; bits above 47 drop out on each shift
    function automatic logic [ACC_W-1:0] crc_divide(input logic [ACC_W-1:0] a);
        logic [ACC_W-1:0] v;
        v = a;
        for (int k = 0; k < STEPS; k++) begin
            if (v[ACC_W-1]) begin
                v = v ^ CRC_DIVISOR;
            end
            v = {v[ACC_W-2:0], 1'b0};
        end
        return v;
    endfunction

endpackage

// File: design/pcrc_front.sv
// ----------------------------------------------------------------------------
// pcrc_front
// Input side: accepts words, tags each with its position in the frame and
// pushes it into the queue.
// ----------------------------------------------------------------------------
module pcrc_front
    import pcrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_last,
    input  logic              i_full,
    output logic              o_push,
    output t_entry            o_entry
);

    t_pos r_pos;
    t_pos n_pos;

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_last) begin
                n_pos = POS_FIRST;
            end else begin
                case (r_pos)
                    POS_FIRST:  n_pos = POS_SECOND;
                    POS_SECOND: n_pos = POS_LATER;
                    POS_LATER:  n_pos = POS_LATER;
                    default:    n_pos = POS_FIRST;
                endcase
            end
        end
    end

    always_comb begin
        o_ready       = !i_full;
        o_push        = i_valid && !i_full;
        o_entry.word  = i_word;
        o_entry.last  = i_last;
        o_entry.pos   = r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_FIRST;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// File: design/pcrc_queue.sv
// ----------------------------------------------------------------------------
// pcrc_queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module pcrc_queue
    import pcrc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// File: design/pcrc_back.sv
// ----------------------------------------------------------------------------
// pcrc_back
// Division side: folds each queued word into the accumulator and holds the
// frame result in an output register.
// ----------------------------------------------------------------------------
module pcrc_back
    import pcrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_entry            i_entry,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_crc,
    output logic              o_crc_ok,
    output logic              o_short_block
);

    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic [ACC_W-1:0]  w_sum;
    logic [ACC_W-1:0]  w_div;
    logic [WORD_W-1:0] w_crc;
    logic              w_short;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [WORD_W-1:0] r_crc;
    logic              r_crc_ok;
    logic              r_short;
    logic              w_emit;

    assign w_sum = r_acc + {{(ACC_W-WORD_W){1'b0}}, i_entry.word};
    assign w_div = crc_divide(w_sum);

    always_comb begin
        case (i_entry.pos)
            POS_FIRST: begin
                n_acc   = {i_entry.word, {(ACC_W-WORD_W){1'b0}}};
                w_crc   = '0;
                w_short = 1'b1;
            end
            POS_SECOND: begin
                n_acc   = {w_sum[WORD_W-1:0], {(ACC_W-WORD_W){1'b0}}};
                w_crc   = w_sum[WORD_W-1:0];
                w_short = 1'b0;
            end
            default: begin
                n_acc   = w_div;
                w_crc   = w_div[ACC_W-1:ACC_W-WORD_W];
                w_short = 1'b0;
            end
        endcase
    end

    // a non-final word never needs output space
    assign o_pop  = !i_empty && (!i_entry.last || !r_out_valid || i_ready);
    assign w_emit = o_pop && i_entry.last;

    always_comb begin
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_acc <= n_acc;
        end
        if (w_emit) begin
            r_crc    <= w_crc;
            r_crc_ok <= !w_short && (w_crc == '0);
            r_short  <= w_short;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_crc         = r_crc;
    assign o_crc_ok      = r_crc_ok;
    assign o_short_block = r_short;

endmodule

// File: design/payload_word_crc32_check.sv
// ----------------------------------------------------------------------------
// payload_word_crc32_check
// Payload CRC-32 check (polynomial 0x104C11DB7) over a stream of 32-bit words.
// ----------------------------------------------------------------------------
// Takes one word per clock while the queue is not full. Each word enters a
// QUEUE_DEPTH-entry queue and is folded into the 48-bit remainder as it
// leaves; from a frame's third word on, a single sixteen-step xor-shift stage
// divides it in. The result is registered as the last word leaves. A result
// waiting on the output only holds back the next last word; once that word
// reaches the head of the queue, up to QUEUE_DEPTH - 1 more words are taken
// behind it. A frame of one word reports crc 0 with short_block set. crc_ok
// is 1 for a zero remainder on a frame of two or more words.
// ----------------------------------------------------------------------------
module payload_word_crc32_check
    import pcrc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_crc,
    output logic              o_crc_ok,
    output logic              o_short_block
);

    logic   w_full;
    logic   w_empty;
    logic   w_push;
    logic   w_pop;
    t_entry w_in_entry;
    t_entry w_head;

    pcrc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .i_last  (i_last),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_in_entry)
    );

    pcrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .i_pop   (w_pop),
        .o_entry (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    pcrc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (w_head),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_crc         (o_crc),
        .o_crc_ok      (o_crc_ok),
        .o_short_block (o_short_block)
    );

`ifndef SYNTHESIS
    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("result or back-pressure left over after reset");

    a_short_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_short_block |-> (o_crc == '0) && !o_crc_ok)
        else $error("short frame with non-zero crc or crc_ok");

    a_ok_matches_crc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_short_block |-> o_crc_ok == (o_crc == '0))
        else $error("crc_ok disagrees with remainder");
`endif

endmodule

// File: tb/payload_crc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// payload_crc_checker
// Watches both channels of the payload CRC checker, predicts the result of
// every frame from the accepted words and compares each delivered result,
// field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module payload_crc_checker
    import pcrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_last,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [WORD_W-1:0] i_crc,
    input  logic              i_crc_ok,
    input  logic              i_short_block,
    output int                o_fail_count,
    output int                o_pending
);

    localparam logic [63:0] KEEP47 = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] GEN32  = 64'h0000_0001_04C1_1DB7;

    typedef struct packed {
        logic [WORD_W-1:0] crc;
        logic              crc_ok;
        logic              short_block;
    } t_crc_result;

    logic [63:0] rem_acc;
    t_pos        rem_pos;
    t_crc_result crc_due_q[$];
    int          fails;
    int          due;

    assign o_fail_count = fails;
    assign o_pending    = due;

    initial begin
        rem_acc = '0;
        rem_pos = POS_FIRST;
        fails   = 0;
        due     = 0;
    end

    function automatic logic [63:0] divide16(input logic [63:0] a);
        logic [63:0] v;
        v = a;
        for (int k = 0; k < 16; k++) begin
            if (v[47]) begin
                v = v ^ ((GEN32 & KEEP47) << 15);
            end
            v = (v & KEEP47) << 1;
        end
        return v;
    endfunction

    task automatic fold_word(input logic [WORD_W-1:0] w, input logic l);
        logic        lone;
        t_crc_result r;
        lone = 1'b0;
        case (rem_pos)
            POS_FIRST: begin
                rem_acc = {16'd0, w, 16'd0};
                rem_pos = POS_SECOND;
                lone    = 1'b1;
            end
            POS_SECOND: begin
                rem_acc = ((rem_acc + w) & KEEP47) << 16;
                rem_pos = POS_LATER;
            end
            default: begin
                rem_acc = divide16(rem_acc + w);
            end
        endcase
        if (l) begin
            if (lone) begin
                r.crc         = '0;
                r.crc_ok      = 1'b0;
                r.short_block = 1'b1;
            end else begin
                r.crc         = rem_acc[47:16];
                r.crc_ok      = (rem_acc[47:16] == '0);
                r.short_block = 1'b0;
            end
            crc_due_q = {crc_due_q, r};
            rem_acc = '0;
            rem_pos = POS_FIRST;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_crc_result want;
        if (!i_rst_n) begin
            rem_acc = '0;
            rem_pos = POS_FIRST;
            crc_due_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (crc_due_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result crc=%h ok=%b short=%b",
                             $time, i_crc, i_crc_ok, i_short_block);
                end else begin
                    want = crc_due_q.pop_front();
                    if (i_crc !== want.crc) begin
                        fails++;
                        $display("%0t: crc expected %h actual %h",
                                 $time, want.crc, i_crc);
                    end
                    if (i_crc_ok !== want.crc_ok) begin
                        fails++;
                        $display("%0t: crc_ok expected %b actual %b",
                                 $time, want.crc_ok, i_crc_ok);
                    end
                    if (i_short_block !== want.short_block) begin
                        fails++;
                        $display("%0t: short_block expected %b actual %b",
                                 $time, want.short_block, i_short_block);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                fold_word(i_word, i_last);
            end
        end
        due = crc_due_q.size();
    end

endmodule

// File: tb/tb_payload_word_crc32_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_payload_word_crc32_check
// Drives frames of payload words into the CRC checker: a directed set of
// short, two-word, all-zero and all-ones frames, then random frames of
// mixed length with random idling on both channels, a long output stall
// and a full drain. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_payload_word_crc32_check
    import pcrc_pkg::*;
();

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [WORD_W-1:0] i_word;
    logic              i_last;
    logic              o_valid;
    logic              i_ready;
    logic [WORD_W-1:0] o_crc;
    logic              o_crc_ok;
    logic              o_short_block;

    int fail_count;
    int pending;
    int words_sent;
    bit calm;
    bit hold_sink;

    payload_word_crc32_check i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_word        (i_word),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_crc         (o_crc),
        .o_crc_ok      (o_crc_ok),
        .o_short_block (o_short_block)
    );

    payload_crc_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_word        (i_word),
        .i_last        (i_last),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_crc         (o_crc),
        .i_crc_ok      (o_crc_ok),
        .i_short_block (o_short_block),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb_payload_word_crc32_check NOT OK");
        $finish;
    end

    task automatic push_word(input logic [WORD_W-1:0] w, input logic l);
        i_valid <= 1'b1;
        i_word  <= w;
        i_last  <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic [WORD_W-1:0] draw_word(input int pat);
        case (pat)
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    // result side
    initial begin : sink_drive
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                i_ready <= 1'b0;
                repeat (120) @(posedge i_clk);
                hold_sink = 1'b0;
                i_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int len;
        int shape;
        int pat;
        bit held;
        bit paused;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_word     <= '0;
        i_last     <= 1'b0;
        calm       = 1'b0;
        hold_sink  = 1'b0;
        words_sent = 0;
        held       = 1'b0;
        paused     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-word frames
        push_word(32'h0000_0000, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b1);
        // two-word frames, no division
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h0000_0000, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);
        // carry into the top of the accumulator
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);
        // zero remainder after division, then mixed-pattern frames
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h0000_0000, 1'b1);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'h0000_0001, 1'b0);
        push_word(32'h7FFF_FFFF, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'h1234_5678, 1'b1);
        push_word(32'hAAAA_AAAA, 1'b0);
        push_word(32'h5555_5555, 1'b0);
        push_word(32'hDEAD_BEEF, 1'b1);

        while (words_sent < 1750) begin
            if (words_sent >= 500 && !held) begin
                held      = 1'b1;
                hold_sink = 1'b1;
                repeat (14) begin
                    push_word($urandom, 1'b0);
                    push_word($urandom, 1'b1);
                end
            end
            if (words_sent >= 1000 && !paused) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                @(negedge i_clk);
                wait (pending == 0);
                repeat (10) @(posedge i_clk);
            end
            calm  = (words_sent >= 1450);
            shape = $urandom_range(0, 19);
            if (shape < 14) begin
                len = $urandom_range(1, 6);
            end else if (shape < 18) begin
                len = $urandom_range(7, 20);
            end else begin
                len = $urandom_range(21, 64);
            end
            pat = $urandom_range(0, 9);
            for (int n = 0; n < len; n++) begin
                push_word(draw_word(pat), n == len - 1);
            end
        end

        i_valid <= 1'b0;
        @(negedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_payload_word_crc32_check OK");
        end else begin
            $display("tb_payload_word_crc32_check NOT OK");
        end
        $finish;
    end

endmodule
